[rtl/core/lgs_pkg.sv]
// Shared constants for the line-to-glyph segment stepper.
`default_nettype none
package lgs_pkg;

  // Grid pitch in device units, as a power of two.
  localparam int GRID_LOG2   = 2;
  localparam int GRID_STEP   = 1 << GRID_LOG2;
  // Candidate steps per axis for one segment.
  localparam int GRID_SPAN   = 3;
  // Vertical glyph offset rows, as a power of two.
  localparam int ROWS_LOG2   = 2;
  // Longest drawable span in grid units.
  localparam int MAX_SPAN    = 32;
  // Most segments emitted for one line.
  localparam int MAX_RESULTS = 64;

  localparam int POS_W  = 17;
  localparam int OUT_W  = 16;
  localparam int SX_W   = 15;
  localparam int DX_W   = 13;
  localparam int AX_W   = 11;
  localparam int ROW_W  = 4;
  localparam int STEP_W = 3;
  localparam int TX_W   = $clog2(GRID_SPAN);
  localparam int SPAN_W = $clog2(MAX_SPAN + GRID_SPAN + 1);
  localparam int PROD_W = 2 * SPAN_W;
  localparam int CNT_W  = $clog2(MAX_RESULTS);

  localparam logic [POS_W-1:0] SNAP_HALF = POS_W'(GRID_STEP / 2);
  localparam logic [POS_W-1:0] SNAP_MASK = ~POS_W'(GRID_STEP - 1);
  localparam logic [OUT_W-1:0] BAND_MASK = ~OUT_W'((1 << (GRID_LOG2 + ROWS_LOG2)) - 1);

endpackage
`default_nettype wire

[rtl/core/line_to_glyph_segment_stepper.sv]
// Top level of the line-to-glyph segment stepper: sequencer and shared distance unit.
//
// Usage: one beat on the in_ channel carries a line command (start point in device
// units, signed deltas). The block snaps both end points to the glyph grid and
// walks the line greedily, one segment per out_ beat, each beat giving the
// glyph indices (row_offset, slope_down, step_x, step_y) and its placement.
// The final beat of a line has last set. A line whose snapped span exceeds the
// supported grid span gives one beat with too_long and last set, all else zero.
// A line that snaps to zero length gives no beat at all.
// Timing: in_stall is high from acceptance until the last beat of the line has
// been taken. Setup passes through accept, span and range check. Each segment
// then scans all GRID_SPAN squared candidate steps through the one cross-product
// distance unit, loads the output register and waits for the beat to be taken
// on the out_ channel. A line gives up to 64 segments.
// A stalled out_ beat holds its payload and freezes the walk until taken.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops any
// pending out_ beat.
`default_nettype none
module line_to_glyph_segment_stepper (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [lgs_pkg::SX_W-1:0]  in_start_x,
  input  wire logic [lgs_pkg::SX_W-1:0]  in_start_y,
  input  wire logic [lgs_pkg::DX_W-1:0]  in_delta_x,
  input  wire logic [lgs_pkg::DX_W-1:0]  in_delta_y,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [lgs_pkg::ROW_W-1:0]      out_row_offset,
  output logic                           out_slope_down,
  output logic [lgs_pkg::STEP_W-1:0]     out_step_x,
  output logic [lgs_pkg::STEP_W-1:0]     out_step_y,
  output logic [lgs_pkg::OUT_W-1:0]      out_place_x,
  output logic [lgs_pkg::OUT_W-1:0]      out_place_y,
  output logic                           out_last,
  output logic                           out_too_long
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SPAN,
    S_CHECK,
    S_SCAN,
    S_EMIT,
    S_WAIT
  } state_t;

  state_t state_r;

  // Pen position and snapped end point, two's complement.
  logic [lgs_pkg::POS_W-1:0]  x_r, y_r, ex_r, ey_r;
  logic                       xneg_r, yneg_r;
  // Absolute snapped span in grid units.
  logic [lgs_pkg::AX_W-1:0]   ax_r, ay_r;
  // Grid units walked so far.
  logic [lgs_pkg::SPAN_W-1:0] cx_r, cy_r;
  // Candidate scan.
  logic [lgs_pkg::TX_W-1:0]   tx_r, ty_r, bx_r, by_r;
  logic                       found_r;
  logic [lgs_pkg::PROD_W-1:0] best_r;
  logic [lgs_pkg::CNT_W-1:0]  n_r;
  logic                       done_r;
  logic                       out_valid_r;

  logic [lgs_pkg::ROW_W-1:0]  row_r;
  logic                       slope_r;
  logic [lgs_pkg::STEP_W-1:0] stx_r, sty_r;
  logic [lgs_pkg::OUT_W-1:0]  plx_r, ply_r;
  logic                       last_r, too_long_r;

  // Snap on accept: add half a grid step and clear the low bits.
  logic [lgs_pkg::POS_W-1:0] sx_ext, sy_ext, ex_raw, ey_raw;
  assign sx_ext = lgs_pkg::POS_W'(in_start_x);
  assign sy_ext = lgs_pkg::POS_W'(in_start_y);
  assign ex_raw = sx_ext + lgs_pkg::POS_W'($signed(in_delta_x)) + lgs_pkg::SNAP_HALF;
  assign ey_raw = sy_ext + lgs_pkg::POS_W'($signed(in_delta_y)) + lgs_pkg::SNAP_HALF;

  // Span: absolute difference of snapped end points, in grid units.
  logic [lgs_pkg::POS_W-1:0] dx, dy, adx, ady;
  assign dx  = ex_r - x_r;
  assign dy  = ey_r - y_r;
  assign adx = dx[lgs_pkg::POS_W-1] ? (~dx + 1'b1) : dx;
  assign ady = dy[lgs_pkg::POS_W-1] ? (~dy + 1'b1) : dy;

  logic too_long_c, zero_c;
  assign too_long_c = (ax_r > lgs_pkg::AX_W'(lgs_pkg::MAX_SPAN))
                   || (ay_r > lgs_pkg::AX_W'(lgs_pkg::MAX_SPAN));
  assign zero_c     = (ax_r == '0) && (ay_r == '0);

  // Shared distance unit: |(cy+ty)*ax - (cx+tx)*ay| for the current candidate.
  logic [lgs_pkg::SPAN_W-1:0]   ax_s, ay_s, nx, ny;
  logic [lgs_pkg::PROD_W-1:0]   p_y, p_x, cand_dev;
  logic [lgs_pkg::PROD_W:0]     diff;
  logic                         cand_ok, take;
  assign ax_s     = ax_r[lgs_pkg::SPAN_W-1:0];
  assign ay_s     = ay_r[lgs_pkg::SPAN_W-1:0];
  assign nx       = cx_r + lgs_pkg::SPAN_W'(tx_r);
  assign ny       = cy_r + lgs_pkg::SPAN_W'(ty_r);
  assign p_y      = lgs_pkg::PROD_W'(ny) * lgs_pkg::PROD_W'(ax_s);
  assign p_x      = lgs_pkg::PROD_W'(nx) * lgs_pkg::PROD_W'(ay_s);
  assign diff     = {1'b0, p_y} - {1'b0, p_x};
  assign cand_dev = diff[lgs_pkg::PROD_W] ? lgs_pkg::PROD_W'(~diff + 1'b1)
                                          : diff[lgs_pkg::PROD_W-1:0];
  assign cand_ok  = !((tx_r == '0) && (ty_r == '0)) && (nx <= ax_s) && (ny <= ay_s);
  // Ties go to the later candidate.
  assign take     = cand_ok && (!found_r || (cand_dev <= best_r));

  logic scan_end;
  assign scan_end = (tx_r == lgs_pkg::TX_W'(lgs_pkg::GRID_SPAN - 1))
                 && (ty_r == lgs_pkg::TX_W'(lgs_pkg::GRID_SPAN - 1));

  // Segment placement from the chosen step.
  logic [lgs_pkg::POS_W-1:0]  xmag, ymag, lx, ly;
  logic [lgs_pkg::SPAN_W-1:0] cx_nxt, cy_nxt;
  assign xmag   = lgs_pkg::POS_W'(bx_r) << lgs_pkg::GRID_LOG2;
  assign ymag   = lgs_pkg::POS_W'(by_r) << lgs_pkg::GRID_LOG2;
  assign lx     = xneg_r ? (x_r - xmag) : x_r;
  assign ly     = yneg_r ? (y_r - ymag) : y_r;
  assign cx_nxt = cx_r + lgs_pkg::SPAN_W'(bx_r);
  assign cy_nxt = cy_r + lgs_pkg::SPAN_W'(by_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      done_r      <= 1'b0;
      n_r         <= '0;
      tx_r        <= '0;
      ty_r        <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            x_r     <= (sx_ext + lgs_pkg::SNAP_HALF) & lgs_pkg::SNAP_MASK;
            y_r     <= (sy_ext + lgs_pkg::SNAP_HALF) & lgs_pkg::SNAP_MASK;
            ex_r    <= ex_raw & lgs_pkg::SNAP_MASK;
            ey_r    <= ey_raw & lgs_pkg::SNAP_MASK;
            xneg_r  <= in_delta_x[lgs_pkg::DX_W-1];
            yneg_r  <= in_delta_y[lgs_pkg::DX_W-1];
            state_r <= S_SPAN;
          end
        end
        S_SPAN: begin
          ax_r    <= adx[lgs_pkg::GRID_LOG2 +: lgs_pkg::AX_W];
          ay_r    <= ady[lgs_pkg::GRID_LOG2 +: lgs_pkg::AX_W];
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          cx_r    <= '0;
          cy_r    <= '0;
          n_r     <= '0;
          tx_r    <= '0;
          ty_r    <= '0;
          found_r <= 1'b0;
          if (too_long_c) begin
            // Flag the line and draw nothing.
            row_r       <= '0;
            slope_r     <= 1'b0;
            stx_r       <= '0;
            sty_r       <= '0;
            plx_r       <= '0;
            ply_r       <= '0;
            last_r      <= 1'b1;
            too_long_r  <= 1'b1;
            done_r      <= 1'b1;
            out_valid_r <= 1'b1;
            state_r     <= S_WAIT;
          end else if (zero_c) begin
            state_r <= S_IDLE;
          end else begin
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (take) begin
            found_r <= 1'b1;
            best_r  <= cand_dev;
            bx_r    <= tx_r;
            by_r    <= ty_r;
          end
          if (tx_r == lgs_pkg::TX_W'(lgs_pkg::GRID_SPAN - 1)) begin
            tx_r <= '0;
            ty_r <= ty_r + 1'b1;
          end else begin
            tx_r <= tx_r + 1'b1;
          end
          if (scan_end) begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          row_r          <= lgs_pkg::ROW_W'(ly[lgs_pkg::GRID_LOG2 +: lgs_pkg::ROWS_LOG2]);
          slope_r        <= xneg_r ^ yneg_r;
          stx_r          <= lgs_pkg::STEP_W'(bx_r);
          sty_r          <= lgs_pkg::STEP_W'(by_r);
          plx_r          <= lx[lgs_pkg::OUT_W-1:0];
          ply_r          <= ly[lgs_pkg::OUT_W-1:0] & lgs_pkg::BAND_MASK;
          last_r         <= (cx_nxt == ax_s) && (cy_nxt == ay_s);
          too_long_r     <= 1'b0;
          done_r         <= (cx_nxt == ax_s) && (cy_nxt == ay_s);
          // Advance the pen past this segment.
          x_r            <= xneg_r ? (x_r - xmag) : (x_r + xmag);
          y_r            <= yneg_r ? (y_r - ymag) : (y_r + ymag);
          cx_r           <= cx_nxt;
          cy_r           <= cy_nxt;
          out_valid_r    <= 1'b1;
          state_r        <= S_WAIT;
        end
        S_WAIT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            n_r         <= n_r + 1'b1;
            tx_r        <= '0;
            ty_r        <= '0;
            found_r     <= 1'b0;
            if (done_r || (n_r == lgs_pkg::CNT_W'(lgs_pkg::MAX_RESULTS - 1))) begin
              state_r <= S_IDLE;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_row_offset = row_r;
  assign out_slope_down = slope_r;
  assign out_step_x     = stx_r;
  assign out_step_y     = sty_r;
  assign out_place_x    = plx_r;
  assign out_place_y    = ply_r;
  assign out_last       = last_r;
  assign out_too_long   = too_long_r;

endmodule
`default_nettype wire
